>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the formatter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> hw/rtl/ipf_pkg.sv
// Shared types, codes and helpers of the integer printf formatter.
`timescale 1ns / 1ps
package ipf_pkg;

  localparam int MAX_WIDTH_DEF = 64;

  // Digit store: 22 slots of 4 bits covers 22 octal, 20 decimal or 16 hex digits
  localparam int NDIG     = 22;
  localparam int DIG_BITS = NDIG * 4;

  // Configuration register indexes
  localparam logic [2:0] REG_RADIX_MODE     = 3'd0;
  localparam logic [2:0] REG_ARG_SIZE       = 3'd1;
  localparam logic [2:0] REG_FIELD_WIDTH    = 3'd2;
  localparam logic [2:0] REG_PRECISION      = 3'd3;
  localparam logic [2:0] REG_LEFT_ALIGN     = 3'd4;
  localparam logic [2:0] REG_SIGN_MODE      = 3'd5;
  localparam logic [2:0] REG_ALTERNATE_FORM = 3'd6;
  localparam logic [2:0] REG_ZERO_PAD       = 3'd7;

  // Radix modes
  localparam logic [2:0] RADIX_SDEC = 3'd0;
  localparam logic [2:0] RADIX_UDEC = 3'd1;
  localparam logic [2:0] RADIX_OCT  = 3'd2;
  localparam logic [2:0] RADIX_HEXL = 3'd3;
  localparam logic [2:0] RADIX_HEXU = 3'd4;

  // Argument sizes
  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_32 = 2'd2;
  localparam logic [1:0] SIZE_64 = 2'd3;

  // Sign modes
  localparam logic [1:0] SIGN_NONE  = 2'd0;
  localparam logic [1:0] SIGN_PLUS  = 2'd1;
  localparam logic [1:0] SIGN_SPACE = 2'd2;

  // ASCII characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_UC_X  = 8'h58;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_OCT = 2'd1,
    BASE_HEX = 2'd2
  } base_t;

  typedef struct packed {
    logic [2:0] radix_mode;
    logic [1:0] arg_size;
    logic [6:0] field_width;
    logic [5:0] precision;
    logic       left_align;
    logic [1:0] sign_mode;
    logic       alternate_form;
    logic       zero_pad;
  } cfg_t;

  // Status of the digit converter toward the character sequencer
  typedef struct packed {
    logic       ready;
    logic [4:0] nd;
    logic [3:0] top_digit;
  } conv_stat_t;

  function automatic base_t base_of(input logic [2:0] mode);
    base_t b;
    case (mode)
      RADIX_OCT:  b = BASE_OCT;
      RADIX_HEXL: b = BASE_HEX;
      RADIX_HEXU: b = BASE_HEX;
      default:    b = BASE_DEC;
    endcase
    return b;
  endfunction

  function automatic logic [6:0] arg_bits(input logic [1:0] size);
    logic [6:0] n;
    case (size)
      SIZE_8:  n = 7'd8;
      SIZE_16: n = 7'd16;
      SIZE_32: n = 7'd32;
      SIZE_64: n = 7'd64;
      default: n = 7'd64;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'b0, d};
    end else begin
      c = (upper ? CH_UC_A : CH_LC_A) + {4'b0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/ipf_conv.sv
// Binary to digit converter (bit-serial for decimal) with leading-zero normalization.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ipf_conv (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  logic [63:0]           mag,
  input  ipf_pkg::base_t        base,
  input  logic [1:0]            arg_size,
  input  logic                  shift,
  output ipf_pkg::conv_stat_t   stat
);

  localparam int DB = ipf_pkg::DIG_BITS;

  typedef enum logic [3:0] {
    C_IDLE   = 4'b0001,
    C_DABBLE = 4'b0010,
    C_NORM   = 4'b0100,
    C_DONE   = 4'b1000
  } cstate_t;

  cstate_t       state_r, state_nxt;
  logic [DB-1:0] dig_r, dig_nxt;
  logic [63:0]   bin_r, bin_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic [4:0]    nd_r, nd_nxt;

  logic [DB-1:0] corr;
  logic [DB-1:0] oct_dig;
  logic [65:0]   mag_ext;
  logic [63:0]   aligned;
  logic [3:0]    top;
  logic [6:0]    nbits;

  assign top     = dig_r[DB-1 -: 4];
  assign mag_ext = {2'b00, mag};
  assign nbits   = ipf_pkg::arg_bits(arg_size);

  // Add-3 correction on every BCD slot before the dabble's one-bit shift; also the octal digit split
  always_comb begin
    logic [3:0] nib;
    nib = 4'd0;
    for (int i = 0; i < ipf_pkg::NDIG; i++) begin
      nib = dig_r[4*i +: 4];
      corr[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
      oct_dig[4*i +: 4] = {1'b0, mag_ext[3*i +: 3]};
    end
  end

  // Left-align the argument so its top bit leads the shift
  always_comb begin
    case (arg_size)
      ipf_pkg::SIZE_8:  aligned = {mag[7:0], 56'b0};
      ipf_pkg::SIZE_16: aligned = {mag[15:0], 48'b0};
      ipf_pkg::SIZE_32: aligned = {mag[31:0], 32'b0};
      default:          aligned = mag;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    dig_nxt   = dig_r;
    bin_nxt   = bin_r;
    cnt_nxt   = cnt_r;
    nd_nxt    = nd_r;
    if (load) begin
      case (base)
        ipf_pkg::BASE_OCT: begin
          dig_nxt   = oct_dig;
          nd_nxt    = 5'(ipf_pkg::NDIG);
          state_nxt = C_NORM;
        end
        ipf_pkg::BASE_HEX: begin
          dig_nxt   = {aligned, {(DB-64){1'b0}}};
          nd_nxt    = nbits[6:2];
          state_nxt = C_NORM;
        end
        default: begin
          dig_nxt   = '0;
          bin_nxt   = aligned;
          cnt_nxt   = nbits;
          state_nxt = C_DABBLE;
        end
      endcase
    end else begin
      case (state_r)
        C_DABBLE: begin
          dig_nxt = {corr[DB-2:0], bin_r[63]};
          bin_nxt = {bin_r[62:0], 1'b0};
          cnt_nxt = cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            nd_nxt    = 5'(ipf_pkg::NDIG);
            state_nxt = C_NORM;
          end
        end
        C_NORM: begin
          // drop one leading zero digit per cycle, keep at least one
          if (nd_r > 5'd1 && top == 4'd0) begin
            dig_nxt = {dig_r[DB-5:0], 4'b0};
            nd_nxt  = nd_r - 5'd1;
          end else begin
            state_nxt = C_DONE;
          end
        end
        C_DONE: begin
          if (shift) begin
            dig_nxt = {dig_r[DB-5:0], 4'b0};
          end
        end
        default: state_nxt = state_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
    bin_r <= bin_nxt;
    cnt_r <= cnt_nxt;
    nd_r  <= nd_nxt;
  end

  assign stat.ready     = (state_r == C_DONE);
  assign stat.nd        = nd_r;
  assign stat.top_digit = top;

  `ASSERT_IMPL(a_ready_nd_range, clk, rst_n, stat.ready,
               (nd_r != 5'd0) && (nd_r <= 5'(ipf_pkg::NDIG)))
  `ASSERT_NEXT(a_dabble_ends, clk, rst_n, (state_r == C_DABBLE) && (cnt_r == 7'd1) && !load,
               state_r == C_NORM)

endmodule

>>> hw/rtl/ipf_emit.sv
// Field layout and one-character-per-cycle text sequencer.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ipf_emit #(
  parameter int MAX_WIDTH = ipf_pkg::MAX_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                arm,
  input  ipf_pkg::cfg_t       cfg,
  input  logic                neg,
  input  logic                nz,
  input  ipf_pkg::conv_stat_t stat,
  output logic                shift,
  output logic                busy,
  output logic                out_valid,
  output logic [7:0]          out_char,
  output logic                out_last
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam logic [6:0] MAXW7 = 7'(MAX_WIDTH);

  typedef enum logic [2:0] {
    E_IDLE = 3'b001,
    E_WAIT = 3'b010,
    E_RUN  = 3'b100
  } estate_t;

  estate_t        state_r, state_nxt;
  logic [6:0]     lead_r, lead_nxt;
  logic [6:0]     zeros_r, zeros_nxt;
  logic [4:0]     nd_r, nd_nxt;
  logic [15:0]    pfx_r, pfx_nxt;
  logic [1:0]     pfx_cnt_r, pfx_cnt_nxt;
  logic [CW-1:0]  emit_r, emit_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     out_char_r, out_char_nxt;
  logic           out_last_r, out_last_nxt;

  ipf_pkg::base_t base;
  logic           is_signed, upper, has_sign, has_hex;
  logic [7:0]     sign_ch;
  logic [5:0]     nd6, zeros0;
  logic [1:0]     plen;
  logic [6:0]     body, pad, total, lead_p, zeros_p;
  logic [CW-1:0]  emit_p, cnt_inc;
  logic           last_now;

  // Layout of the field from the digit count
  always_comb begin
    base      = ipf_pkg::base_of(cfg.radix_mode);
    is_signed = (cfg.radix_mode == ipf_pkg::RADIX_SDEC);
    upper     = (cfg.radix_mode == ipf_pkg::RADIX_HEXU);
    has_sign  = is_signed && (neg || cfg.sign_mode == ipf_pkg::SIGN_PLUS ||
                              cfg.sign_mode == ipf_pkg::SIGN_SPACE);
    sign_ch   = neg ? ipf_pkg::CH_MINUS :
                (cfg.sign_mode == ipf_pkg::SIGN_PLUS) ? ipf_pkg::CH_PLUS : ipf_pkg::CH_SPACE;
    has_hex   = cfg.alternate_form && nz && (base == ipf_pkg::BASE_HEX);
    nd6       = {1'b0, stat.nd};
    zeros0    = (cfg.precision > nd6) ? cfg.precision - nd6 : 6'd0;
    if (cfg.alternate_form && nz && base == ipf_pkg::BASE_OCT && zeros0 == 6'd0) begin
      zeros0 = 6'd1;
    end
    plen    = has_sign ? 2'd1 : (has_hex ? 2'd2 : 2'd0);
    body    = 7'(plen) + 7'(zeros0) + 7'(stat.nd);
    pad     = (cfg.field_width > body) ? cfg.field_width - body : 7'd0;
    lead_p  = 7'd0;
    zeros_p = 7'(zeros0);
    if (!cfg.left_align) begin
      if (cfg.zero_pad && cfg.precision == 6'd0) begin
        zeros_p = 7'(zeros0) + pad;
      end else begin
        lead_p = pad;
      end
    end
    total  = body + pad;
    emit_p = (total < MAXW7) ? CW'(total) : CW'(MAX_WIDTH);
  end

  assign cnt_inc  = cnt_r + CW'(1);
  assign last_now = (cnt_inc == emit_r);
  assign shift    = (state_r == E_RUN) && (lead_r == 7'd0) && (pfx_cnt_r == 2'd0) &&
                    (zeros_r == 7'd0) && (nd_r != 5'd0);

  always_comb begin
    state_nxt     = state_r;
    lead_nxt      = lead_r;
    zeros_nxt     = zeros_r;
    nd_nxt        = nd_r;
    pfx_nxt       = pfx_r;
    pfx_cnt_nxt   = pfx_cnt_r;
    emit_nxt      = emit_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = 1'b0;
    case (state_r)
      E_IDLE: begin
        if (arm) begin
          state_nxt = E_WAIT;
        end
      end
      E_WAIT: begin
        if (stat.ready) begin
          lead_nxt    = lead_p;
          zeros_nxt   = zeros_p;
          nd_nxt      = stat.nd;
          pfx_nxt     = has_sign ? {sign_ch, 8'h00} :
                        {ipf_pkg::CH_ZERO, (upper ? ipf_pkg::CH_UC_X : ipf_pkg::CH_LC_X)};
          pfx_cnt_nxt = plen;
          emit_nxt    = emit_p;
          cnt_nxt     = '0;
          state_nxt   = E_RUN;
        end
      end
      E_RUN: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = last_now;
        cnt_nxt       = cnt_inc;
        if (lead_r != 7'd0) begin
          out_char_nxt = ipf_pkg::CH_SPACE;
          lead_nxt     = lead_r - 7'd1;
        end else if (pfx_cnt_r != 2'd0) begin
          out_char_nxt = pfx_r[15:8];
          pfx_nxt      = {pfx_r[7:0], 8'h00};
          pfx_cnt_nxt  = pfx_cnt_r - 2'd1;
        end else if (zeros_r != 7'd0) begin
          out_char_nxt = ipf_pkg::CH_ZERO;
          zeros_nxt    = zeros_r - 7'd1;
        end else if (nd_r != 5'd0) begin
          out_char_nxt = ipf_pkg::digit_char(stat.top_digit, upper);
          nd_nxt       = nd_r - 5'd1;
        end else begin
          out_char_nxt = ipf_pkg::CH_SPACE;
        end
        if (last_now) begin
          state_nxt = E_IDLE;
        end
      end
      default: state_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= E_IDLE;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lead_r     <= lead_nxt;
    zeros_r    <= zeros_nxt;
    nd_r       <= nd_nxt;
    pfx_r      <= pfx_nxt;
    pfx_cnt_r  <= pfx_cnt_nxt;
    emit_r     <= emit_nxt;
    cnt_r      <= cnt_nxt;
    out_char_r <= out_char_nxt;
  end

  assign busy      = (state_r != E_IDLE);
  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  `ASSERT_IMPL(a_shift_when_ready, clk, rst_n, shift, stat.ready)
  `ASSERT_NEXT(a_valid_from_run, clk, rst_n, state_r != E_RUN, !out_valid_r)
  `ASSERT_IMPL(a_last_ends_request, clk, rst_n, out_last_r, state_r == E_IDLE)

endmodule

>>> hw/rtl/integer_printf_formatter.sv
// Top level of the printf-style integer formatter: config registers, sign stage, units.
`timescale 1ns / 1ps
// Steps: decimal values shift through the bit-serial double dabble one argument bit at a time,
//   then leading zero digits are dropped (22 slots, or bits/4 for hex) before the first character.
// One request at a time: busy stays high through the conversion and until the last of up to
//   MAX_WIDTH characters has left the one-char sequencer.
// A new request is taken in the cycle the last character sits on the ports.
// Reset (synchronous, rst_n low) restores register defaults and idles both units.
module integer_printf_formatter #(
  parameter int MAX_WIDTH = ipf_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_value_bits,
  output logic        out_valid,
  output logic [7:0]  out_text_char,
  output logic        out_last_char,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_wdata
);

  // Configuration registers
  logic [2:0] radix_mode_r, radix_mode_nxt;
  logic [1:0] arg_size_r, arg_size_nxt;
  logic [6:0] field_width_r, field_width_nxt;
  logic [5:0] precision_r, precision_nxt;
  logic       left_align_r, left_align_nxt;
  logic [1:0] sign_mode_r, sign_mode_nxt;
  logic       alternate_form_r, alternate_form_nxt;
  logic       zero_pad_r, zero_pad_nxt;

  // Per-request flags kept for the layout step
  logic       neg_r, neg_nxt;
  logic       nz_r, nz_nxt;

  ipf_pkg::cfg_t       cfg;
  ipf_pkg::conv_stat_t stat;
  logic                accept;
  logic                shift;
  logic                is_signed;
  logic                sbit;
  logic [63:0]         masked, sext, mag;

  assign accept = start && !busy;

  // Write the addressed register; each keeps only its own width
  always_comb begin
    radix_mode_nxt     = radix_mode_r;
    arg_size_nxt       = arg_size_r;
    field_width_nxt    = field_width_r;
    precision_nxt      = precision_r;
    left_align_nxt     = left_align_r;
    sign_mode_nxt      = sign_mode_r;
    alternate_form_nxt = alternate_form_r;
    zero_pad_nxt       = zero_pad_r;
    if (cfg_we) begin
      case (cfg_index)
        ipf_pkg::REG_RADIX_MODE:     radix_mode_nxt     = cfg_wdata[2:0];
        ipf_pkg::REG_ARG_SIZE:       arg_size_nxt       = cfg_wdata[1:0];
        ipf_pkg::REG_FIELD_WIDTH:    field_width_nxt    = cfg_wdata;
        ipf_pkg::REG_PRECISION:      precision_nxt      = cfg_wdata[5:0];
        ipf_pkg::REG_LEFT_ALIGN:     left_align_nxt     = cfg_wdata[0];
        ipf_pkg::REG_SIGN_MODE:      sign_mode_nxt      = cfg_wdata[1:0];
        ipf_pkg::REG_ALTERNATE_FORM: alternate_form_nxt = cfg_wdata[0];
        ipf_pkg::REG_ZERO_PAD:       zero_pad_nxt       = cfg_wdata[0];
        default:                     radix_mode_nxt     = radix_mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_mode_r     <= ipf_pkg::RADIX_SDEC;
      arg_size_r       <= ipf_pkg::SIZE_32;
      field_width_r    <= 7'd0;
      precision_r      <= 6'd0;
      left_align_r     <= 1'b0;
      sign_mode_r      <= ipf_pkg::SIGN_NONE;
      alternate_form_r <= 1'b0;
      zero_pad_r       <= 1'b0;
    end else begin
      radix_mode_r     <= radix_mode_nxt;
      arg_size_r       <= arg_size_nxt;
      field_width_r    <= field_width_nxt;
      precision_r      <= precision_nxt;
      left_align_r     <= left_align_nxt;
      sign_mode_r      <= sign_mode_nxt;
      alternate_form_r <= alternate_form_nxt;
      zero_pad_r       <= zero_pad_nxt;
    end
  end

  assign cfg.radix_mode     = radix_mode_r;
  assign cfg.arg_size       = arg_size_r;
  assign cfg.field_width    = field_width_r;
  assign cfg.precision      = precision_r;
  assign cfg.left_align     = left_align_r;
  assign cfg.sign_mode      = sign_mode_r;
  assign cfg.alternate_form = alternate_form_r;
  assign cfg.zero_pad       = zero_pad_r;

  // Cut the argument to its size, sign-extend in signed decimal and take the magnitude
  assign is_signed = (radix_mode_r == ipf_pkg::RADIX_SDEC);

  always_comb begin
    case (arg_size_r)
      ipf_pkg::SIZE_8: begin
        sbit   = in_value_bits[7];
        masked = {56'b0, in_value_bits[7:0]};
        sext   = {{56{in_value_bits[7]}}, in_value_bits[7:0]};
      end
      ipf_pkg::SIZE_16: begin
        sbit   = in_value_bits[15];
        masked = {48'b0, in_value_bits[15:0]};
        sext   = {{48{in_value_bits[15]}}, in_value_bits[15:0]};
      end
      ipf_pkg::SIZE_32: begin
        sbit   = in_value_bits[31];
        masked = {32'b0, in_value_bits[31:0]};
        sext   = {{32{in_value_bits[31]}}, in_value_bits[31:0]};
      end
      default: begin
        sbit   = in_value_bits[63];
        masked = in_value_bits;
        sext   = in_value_bits;
      end
    endcase
    neg_nxt = neg_r;
    nz_nxt  = nz_r;
    if (accept) begin
      neg_nxt = is_signed && sbit;
      nz_nxt  = |masked;
    end
    mag = (is_signed && sbit) ? (~sext + 64'd1) : masked;
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    nz_r  <= nz_nxt;
  end

  // Digit converter: bit-serial double dabble for decimal, direct split for octal and hex
  ipf_conv u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .mag      (mag),
    .base     (ipf_pkg::base_of(radix_mode_r)),
    .arg_size (arg_size_r),
    .shift    (shift),
    .stat     (stat)
  );

  // Layout and character sequencer; it owns busy and the result strobe
  ipf_emit #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .arm       (accept),
    .cfg       (cfg),
    .neg       (neg_r),
    .nz        (nz_r),
    .stat      (stat),
    .shift     (shift),
    .busy      (busy),
    .out_valid (out_valid),
    .out_char  (out_text_char),
    .out_last  (out_last_char)
  );

endmodule
